// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/dva_pkg.sv -----
// ----------------------------------------------------------------------------
// dva_pkg
// Types, constants, month table and microcode store for the date advancer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dva_pkg;

  localparam int DVA_COUNT_BITS = 16;
  localparam int DVA_YEAR_BITS  = 14;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 16;

  // floor(y / 25) = (y * DIV25_MUL) >> DIV25_SHIFT, exact for y < 2^16
  localparam int               DIV25_MUL_W = 17;
  localparam logic [16:0]      DIV25_MUL   = 17'd83887;
  localparam int               DIV25_SHIFT = 21;
  localparam int               DIV25_DEN   = 25;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] LEN_LONG  = 5'd31;
  localparam logic [DAY_W-1:0] LEN_SHORT = 5'd30;
  localparam logic [DAY_W-1:0] LEN_LEAP  = 5'd29;
  localparam logic [DAY_W-1:0] LEN_FEB   = 5'd28;

  localparam int STEP_BITS = 3;
  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_MUL   = 3'd1;
  localparam step_t STEP_LEAP  = 3'd2;
  localparam step_t STEP_CHECK = 3'd3;
  localparam step_t STEP_ADV   = 3'd4;
  localparam step_t STEP_EMIT  = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_LOAD  = 3'd1,
    OP_MULQ  = 3'd2,
    OP_LEAP  = 3'd3,
    OP_CHECK = 3'd4,
    OP_ADV   = 3'd5,
    OP_EMIT  = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_IN_VALID  = 3'd2,
    COND_OUT_FREE  = 3'd3,
    COND_LEFT_ZERO = 3'd4,
    COND_WRAP      = 3'd5,
    COND_BAD       = 3'd6
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond_a;
    step_t jmp_a;
    cond_t cond_b;
    step_t jmp_b;
    logic  hold;
  } ctl_t;

  typedef struct packed {
    logic left_zero;
    logic wrap;
    logic bad;
    logic out_free;
  } stat_t;

  function automatic logic [DAY_W-1:0] dva_month_len(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
    logic [DAY_W-1:0] len;
    len = LEN_LONG;
    if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      len = LEN_SHORT;
    end else if (m == MONTH_FEB) begin
      len = leap ? LEN_LEAP : LEN_FEB;
    end
    return len;
  endfunction

  // jump on cond_a first, then cond_b; else hold or fall through
  function automatic ctl_t dva_ucode(input step_t s);
    ctl_t w;
    case (s)
      STEP_IDLE:  w = '{OP_LOAD,  COND_IN_VALID,  STEP_MUL,  COND_NEVER, STEP_IDLE, 1'b1};
      STEP_MUL:   w = '{OP_MULQ,  COND_NEVER,     STEP_IDLE, COND_NEVER, STEP_IDLE, 1'b0};
      STEP_LEAP:  w = '{OP_LEAP,  COND_NEVER,     STEP_IDLE, COND_NEVER, STEP_IDLE, 1'b0};
      STEP_CHECK: w = '{OP_CHECK, COND_BAD,       STEP_EMIT, COND_NEVER, STEP_IDLE, 1'b0};
      STEP_ADV:   w = '{OP_ADV,   COND_LEFT_ZERO, STEP_EMIT, COND_WRAP,  STEP_MUL,  1'b1};
      STEP_EMIT:  w = '{OP_EMIT,  COND_OUT_FREE,  STEP_IDLE, COND_NEVER, STEP_IDLE, 1'b1};
      default:    w = '{OP_NOP,   COND_ALWAYS,    STEP_IDLE, COND_NEVER, STEP_IDLE, 1'b0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/dva_ifs.sv -----
// ----------------------------------------------------------------------------
// dva_ifs
// Request and result channels of the date advancer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dva_in_if import dva_pkg::*;;
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   in_day;
  logic [MONTH_W-1:0] in_month;
  logic [YEAR_W-1:0]  in_year;
  logic [COUNT_W-1:0] days_to_add;

  modport source (output valid, in_day, in_month, in_year, days_to_add, input ready);
  modport sink   (input valid, in_day, in_month, in_year, days_to_add, output ready);
endinterface

interface dva_out_if import dva_pkg::*;;
  logic               valid;
  logic               ready;
  logic               date_valid;
  logic [DAY_W-1:0]   out_day;
  logic [MONTH_W-1:0] out_month;
  logic [YEAR_W-1:0]  out_year;

  modport source (output valid, date_valid, out_day, out_month, out_year, input ready);
  modport sink   (input valid, date_valid, out_day, out_month, out_year, output ready);
endinterface

`default_nettype wire

// ----- hdl/dva_sequencer.sv -----
// ----------------------------------------------------------------------------
// dva_sequencer
// Step counter over the microcode store with two-way conditional jumps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dva_sequencer import dva_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire stat_t stat,
  output ctl_t       ctl,
  output step_t      step
);

  step_t upc_r, upc_nxt;

  function automatic logic cond_hit(input cond_t c, input logic iv, input stat_t st);
    logic hit;
    case (c)
      COND_NEVER:     hit = 1'b0;
      COND_ALWAYS:    hit = 1'b1;
      COND_IN_VALID:  hit = iv;
      COND_OUT_FREE:  hit = st.out_free;
      COND_LEFT_ZERO: hit = st.left_zero;
      COND_WRAP:      hit = st.wrap;
      COND_BAD:       hit = st.bad;
      default:        hit = 1'b0;
    endcase
    return hit;
  endfunction

  assign ctl  = dva_ucode(upc_r);
  assign step = upc_r;

  always_comb begin
    if (cond_hit(ctl.cond_a, in_valid, stat)) begin
      upc_nxt = ctl.jmp_a;
    end else if (cond_hit(ctl.cond_b, in_valid, stat)) begin
      upc_nxt = ctl.jmp_b;
    end else if (ctl.hold) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = upc_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= STEP_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dva_datapath.sv -----
// ----------------------------------------------------------------------------
// dva_datapath
// Date registers, leap-year unit, month skipper and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dva_datapath import dva_pkg::*; #(
  parameter int COUNT_BITS = DVA_COUNT_BITS,
  parameter int YEAR_BITS  = DVA_YEAR_BITS
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire ctl_t           ctl,
  input  wire                 in_valid,
  input  wire [DAY_W-1:0]     in_day,
  input  wire [MONTH_W-1:0]   in_month,
  input  wire [YEAR_W-1:0]    in_year,
  input  wire [COUNT_W-1:0]   days_to_add,
  input  wire                 out_ready,
  output stat_t               stat,
  output logic                out_valid,
  output logic                date_valid,
  output logic [DAY_W-1:0]    out_day,
  output logic [MONTH_W-1:0]  out_month,
  output logic [YEAR_W-1:0]   out_year
);

  localparam int Q_BITS = YEAR_BITS - 4;
  localparam int PROD_W = YEAR_BITS + DIV25_MUL_W;

  logic [DAY_W-1:0]      day_r, day_nxt;
  logic [MONTH_W-1:0]    month_r, month_nxt;
  logic [YEAR_BITS-1:0]  year_r, year_nxt;
  logic [COUNT_BITS-1:0] left_r, left_nxt;
  logic [Q_BITS-1:0]     q_r, q_nxt;
  logic                  leap_r, leap_nxt;
  logic                  checked_r, checked_nxt;
  logic                  ok_r, ok_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r;
  logic [DAY_W-1:0]      out_day_r;
  logic [MONTH_W-1:0]    out_month_r;
  logic [YEAR_W-1:0]     out_year_r;

  logic [DAY_W-1:0]      mlen;
  logic [COUNT_BITS-1:0] to_next;
  logic                  left_zero;
  logic                  step_over;
  logic                  date_ok;
  logic [PROD_W-1:0]     prod;
  logic [YEAR_BITS:0]    q25;
  logic                  div4, div16, div25, leap_calc;
  logic                  out_free;
  logic                  emit;

  assign mlen      = dva_month_len(month_r, leap_r);
  assign to_next   = COUNT_BITS'(mlen) - COUNT_BITS'(day_r) + COUNT_BITS'(1);
  assign left_zero = (left_r == '0);
  assign step_over = (left_r >= to_next);
  assign date_ok   = (month_r != '0) && (month_r <= MONTH_DEC) && (day_r != '0) &&
                     (day_r <= mlen) && (year_r != '0);

  assign prod      = PROD_W'(year_r) * PROD_W'(DIV25_MUL);
  assign q25       = (YEAR_BITS + 1)'(q_r) * (YEAR_BITS + 1)'(DIV25_DEN);
  assign div4      = (year_r[1:0] == 2'b00);
  assign div16     = (year_r[3:0] == 4'b0000);
  assign div25     = (q25 == (YEAR_BITS + 1)'(year_r));
  assign leap_calc = (div16 && div25) || (div4 && !div25);

  assign out_free  = !out_valid_r || out_ready;
  assign emit      = (ctl.op == OP_EMIT) && out_free;

  assign stat.left_zero = left_zero;
  assign stat.wrap      = !left_zero && step_over && (month_r == MONTH_DEC);
  assign stat.bad       = !checked_r && !date_ok;
  assign stat.out_free  = out_free;

  always_comb begin
    day_nxt     = day_r;
    month_nxt   = month_r;
    year_nxt    = year_r;
    left_nxt    = left_r;
    q_nxt       = q_r;
    leap_nxt    = leap_r;
    checked_nxt = checked_r;
    ok_nxt      = ok_r;
    case (ctl.op)
      OP_LOAD: begin
        if (in_valid) begin
          day_nxt     = in_day;
          month_nxt   = in_month;
          year_nxt    = YEAR_BITS'(in_year);
          left_nxt    = COUNT_BITS'(days_to_add);
          checked_nxt = 1'b0;
        end
      end
      OP_MULQ: begin
        q_nxt = prod[DIV25_SHIFT +: Q_BITS];
      end
      OP_LEAP: begin
        leap_nxt = leap_calc;
      end
      OP_CHECK: begin
        if (!checked_r) begin
          checked_nxt = 1'b1;
          ok_nxt      = date_ok;
          if (!date_ok) begin
            day_nxt   = '0;
            month_nxt = '0;
            year_nxt  = '0;
          end
        end
      end
      OP_ADV: begin
        if (!left_zero) begin
          if (step_over) begin
            left_nxt = left_r - to_next;
            day_nxt  = DAY_W'(1);
            if (month_r == MONTH_DEC) begin
              month_nxt = MONTH_JAN;
              year_nxt  = year_r + YEAR_BITS'(1);
            end else begin
              month_nxt = month_r + MONTH_W'(1);
            end
          end else begin
            day_nxt  = day_r + left_r[DAY_W-1:0];
            left_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    day_r   <= day_nxt;
    month_r <= month_nxt;
    year_r  <= year_nxt;
    left_r  <= left_nxt;
    q_r     <= q_nxt;
    leap_r  <= leap_nxt;
    ok_r    <= ok_nxt;
    if (emit) begin
      out_ok_r    <= ok_r;
      out_day_r   <= day_r;
      out_month_r <= month_r;
      out_year_r  <= YEAR_W'(year_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      checked_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      checked_r   <= checked_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign date_valid = out_ok_r;
  assign out_day    = out_day_r;
  assign out_month  = out_month_r;
  assign out_year   = out_year_r;

endmodule

`default_nettype wire

// ----- hdl/date_validate_and_advance.sv -----
// Flow: a request is taken in the load step, then the quotient, leap, check and
// advance steps run and the emit step writes the result; an invalid date goes from
// the check step straight to emit. Each year boundary crossed runs the quotient, leap
// and check steps again. One month is crossed a cycle while no year boundary is crossed.
// One request at a time; the next is taken once the result is in the output register.
// Synchronous active-low reset clears the step counter and output valid; no clearing pass.
// ----------------------------------------------------------------------------
// date_validate_and_advance
// Gregorian date check and day-count advance under microcode control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module date_validate_and_advance import dva_pkg::*; #(
  parameter int COUNT_BITS = DVA_COUNT_BITS,
  parameter int YEAR_BITS  = DVA_YEAR_BITS
) (
  input wire         clk,
  input wire         rst_n,
  dva_in_if.sink     in_req,
  dva_out_if.source  out_rsp
);

  ctl_t  ctl;
  stat_t stat;
  step_t step;
  logic  rsp_zero;
  logic  rsp_in_range;

  assign in_req.ready = (ctl.op == OP_LOAD);

  dva_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .stat     (stat),
    .ctl      (ctl),
    .step     (step)
  );

  dva_datapath #(
    .COUNT_BITS (COUNT_BITS),
    .YEAR_BITS  (YEAR_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .in_valid    (in_req.valid),
    .in_day      (in_req.in_day),
    .in_month    (in_req.in_month),
    .in_year     (in_req.in_year),
    .days_to_add (in_req.days_to_add),
    .out_ready   (out_rsp.ready),
    .stat        (stat),
    .out_valid   (out_rsp.valid),
    .date_valid  (out_rsp.date_valid),
    .out_day     (out_rsp.out_day),
    .out_month   (out_rsp.out_month),
    .out_year    (out_rsp.out_year)
  );

  assign rsp_zero     = (out_rsp.out_day == '0) && (out_rsp.out_month == '0) &&
                        (out_rsp.out_year == '0);
  assign rsp_in_range = (out_rsp.out_month != '0) && (out_rsp.out_month <= MONTH_DEC) &&
                        (out_rsp.out_day != '0);

  `ASSERT_NEXT(a_accept_starts_mul, clk, rst_n, in_req.valid && in_req.ready, step == STEP_MUL)
  `ASSERT_IMPLIES(a_invalid_zero, clk, rst_n, out_rsp.valid && !out_rsp.date_valid, rsp_zero)
  `ASSERT_IMPLIES(a_valid_in_range, clk, rst_n, out_rsp.valid && out_rsp.date_valid, rsp_in_range)

endmodule

`default_nettype wire
